FILE: src/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// shared widths, types and state codes of the modular inverse core
// ----------------------------------------------------------------------------
package mie_pkg;

	localparam int W  = 16;          // operand width
	localparam int TW = W + 2;       // signed bezout coefficient, |t| <= 2*modulus
	localparam int CW = $clog2(W);   // alignment shift count

	typedef logic [W-1:0]         word_t;
	typedef logic signed [TW-1:0] coef_t;
	typedef logic [CW-1:0]        cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_SUB,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic sub;
	} step_ctrl_t;

	typedef struct packed {
		logic can_shift;
		logic last;
	} step_stat_t;

	typedef struct packed {
		word_t rem;
		word_t div;
		coef_t ts;
		coef_t tacc;
	} step_load_t;

endpackage

FILE: src/mie_req_if.sv
// ----------------------------------------------------------------------------
// mie_req_if
// request channel: value and modulus
// ----------------------------------------------------------------------------
interface mie_req_if;
	import mie_pkg::*;

	logic  valid;
	logic  ready;
	word_t value;
	word_t modulus;

	modport source (output valid, value, modulus, input ready);
	modport sink   (input valid, value, modulus, output ready);
endinterface

FILE: src/mie_rsp_if.sv
// ----------------------------------------------------------------------------
// mie_rsp_if
// response channel: inverse and invertible flag
// ----------------------------------------------------------------------------
interface mie_rsp_if;
	import mie_pkg::*;

	logic  valid;
	logic  ready;
	word_t inverse;
	logic  invertible;

	modport source (output valid, inverse, invertible, input ready);
	modport sink   (input valid, inverse, invertible, output ready);
endinterface

FILE: src/mie_step.sv
// ----------------------------------------------------------------------------
// mie_step
// bit-serial shift/subtract divider that also updates the bezout coefficient
// ----------------------------------------------------------------------------
module mie_step (
	input  logic                clk,
	input  mie_pkg::step_ctrl_t ctrl,
	input  mie_pkg::step_load_t ld,
	output mie_pkg::step_stat_t stat,
	output mie_pkg::word_t      rem_nxt,
	output mie_pkg::coef_t      tacc_nxt
);
	import mie_pkg::*;

	word_t rem_q;
	word_t d_q;
	coef_t ts_q;
	coef_t tacc_q;
	cnt_t  cnt_q;
	logic  ge;

	assign ge       = (rem_q >= d_q);
	assign rem_nxt  = ge ? (rem_q - d_q) : rem_q;
	assign tacc_nxt = ge ? (tacc_q - ts_q) : tacc_q;

	// divisor may move up one more place without passing the remainder
	assign stat.can_shift = ({d_q, 1'b0} <= {1'b0, rem_q});
	assign stat.last      = (cnt_q == '0);

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			rem_q  <= ld.rem;
			d_q    <= ld.div;
			ts_q   <= ld.ts;
			tacc_q <= ld.tacc;
			cnt_q  <= '0;
		end else if (ctrl.shift) begin
			d_q   <= {d_q[W-2:0], 1'b0};
			ts_q  <= ts_q <<< 1;
			cnt_q <= cnt_q + 1'b1;
		end else if (ctrl.sub) begin
			rem_q  <= rem_nxt;
			tacc_q <= tacc_nxt;
			d_q    <= d_q >> 1;
			ts_q   <= ts_q >>> 1;
			cnt_q  <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: src/modular_inverse_ext_euclid_core.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core
// modular inverse by the extended euclidean algorithm, one quotient bit a cycle
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                     | handshake
//  --------+-----+-----------------------------------+-------------
//  req     | in  | value, modulus (W bits each)      | valid/ready
//  rsp     | out | inverse (W bits), invertible      | valid/ready
//
//  one request at a time; req.ready is high only while the core is idle
//  each euclid step with a quotient of k+1 bits does divisor alignment,
//  then one restoring subtract per quotient bit; a zero value or modulus
//  skips the iteration and goes straight to registering the result
//  a stalled rsp keeps the finished result; the next request is taken as
//  soon as that result has moved into the output register
//  arst_n clears the sequencer and the output valid, no datapath reset
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core (
	input  logic      clk,
	input  logic      arst_n,
	mie_req_if.sink   req,
	mie_rsp_if.source rsp
);
	import mie_pkg::*;

	state_t     state_q, state_nxt;
	step_ctrl_t ctrl;
	step_load_t ld;
	step_stat_t stat;
	word_t      rem_nxt;
	coef_t      tacc_nxt;

	// euclid pairs: remainder r and its coefficient t with r == t*value mod m
	word_t r0_q, r1_q, m_q;
	coef_t t0_q, t1_q;

	// output register
	logic  ovalid_q;
	word_t inv_q;
	logic  flag_q;

	logic  accept;
	logic  out_load;
	logic  step_done;
	logic  gcd_one;
	coef_t t_pos;

	// ready depends on the state only
	assign req.ready = (state_q == ST_IDLE);

	assign accept    = req.valid && req.ready;
	assign step_done = (state_q == ST_SUB) && stat.last;

	mie_step u_step (
		.clk      (clk),
		.ctrl     (ctrl),
		.ld       (ld),
		.stat     (stat),
		.rem_nxt  (rem_nxt),
		.tacc_nxt (tacc_nxt)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					// zero value or zero modulus: nothing to iterate
					if (req.value == '0 || req.modulus == '0)
						state_nxt = ST_HOLD;
					else
						state_nxt = ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (!stat.can_shift)
					state_nxt = ST_SUB;
			end
			ST_SUB: begin
				if (stat.last)
					state_nxt = (rem_nxt == '0) ? ST_HOLD : ST_ALIGN;
			end
			ST_HOLD: begin
				if (!ovalid_q || rsp.ready)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl.load  = accept || (step_done && rem_nxt != '0);
		ctrl.shift = (state_q == ST_ALIGN) && stat.can_shift;
		ctrl.sub   = (state_q == ST_SUB);
		out_load   = (state_q == ST_HOLD) && (!ovalid_q || rsp.ready);
		if (accept) begin
			ld.rem  = req.modulus;
			ld.div  = req.value;
			ld.ts   = coef_t'(1);
			ld.tacc = '0;
		end else begin
			// next division: old divisor over new remainder
			ld.rem  = r1_q;
			ld.div  = rem_nxt;
			ld.ts   = tacc_nxt;
			ld.tacc = t1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// euclid pair registers
	always_ff @(posedge clk) begin
		if (accept) begin
			r0_q <= req.modulus;
			r1_q <= req.value;
			t0_q <= '0;
			t1_q <= coef_t'(1);
			m_q  <= req.modulus;
		end else if (step_done) begin
			r0_q <= r1_q;
			r1_q <= rem_nxt;
			t0_q <= t1_q;
			t1_q <= tacc_nxt;
		end
	end

	// final fixup: bring a negative coefficient into 0..m-1
	assign gcd_one = (r0_q == word_t'(1));
	assign t_pos   = t0_q[TW-1] ? (t0_q + coef_t'({2'b00, m_q})) : t0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			flag_q <= gcd_one;
			// modulus of one: everything is invertible, inverse reads zero
			inv_q  <= (gcd_one && m_q != word_t'(1)) ? t_pos[W-1:0] : '0;
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.inverse    = inv_q;
	assign rsp.invertible = flag_q;

	// an accepted request always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("request accepted but core stayed idle");

	// no inverse means the inverse field is zero
	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.invertible |-> rsp.inverse == '0)
		else $error("nonzero inverse without invertible flag");

	// a finished result waits in hold while the output is stalled
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD && ovalid_q && !rsp.ready |=> state_q == ST_HOLD)
		else $error("finished result dropped while output stalled");

endmodule

FILE: tb/tb_modular_inverse_ext_euclid_core.sv
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid_core
// self-checking bench for the modular inverse core: a queue-fed driver offers
// value/modulus beats, a predictor works out each inverse by the extended
// euclidean algorithm on wide signed integers, and a monitor compares every
// response beat in order against the predicted results
// ----------------------------------------------------------------------------
module tb_modular_inverse_ext_euclid_core;
	import mie_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 9;
	localparam int HOLD_CYCLES = 400;    // long response stall, fills the core
	localparam int QUIET_LIMIT = 4000;   // cycles without any beat before giving up
	localparam int DRAIN_CYCLES = 200;   // settle time after the last response
	localparam int ITEMS_PER_PHASE = 185;

	typedef struct packed {
		word_t value;
		word_t modulus;
	} inv_req_t;

	typedef struct packed {
		word_t inverse;
		logic  invertible;
	} inv_result_t;

	logic clk;
	logic arst_n;

	mie_req_if req_if ();
	mie_rsp_if rsp_if ();

	modular_inverse_ext_euclid_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	inv_req_t    pending_reqs[$];        // beats not yet offered to the core
	inv_result_t expected_inverses[$];   // predictions for accepted beats, oldest first
	inv_req_t    nxt_req;
	inv_result_t got;
	inv_result_t want;

	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int holds_started;
	int hold_left;
	int quiet_cycles;
	int errors;

	// ------------------------------------------------------------------------
	// predictor: extended euclid with signed bezout coefficient of the value,
	// the coefficient is brought into 0..modulus-1 only at the end
	// ------------------------------------------------------------------------
	function automatic inv_result_t predict_inverse(word_t v, word_t m);
		longint r_prev;
		longint r_cur;
		longint t_prev;
		longint t_cur;
		longint q;
		longint tmp;
		inv_result_t res;
		res.inverse = '0;
		res.invertible = 1'b0;
		// a zero modulus has no ring to invert in
		if (m == '0)
			return res;
		r_prev = longint'(m);
		r_cur = longint'(v) % longint'(m);
		t_prev = 0;
		t_cur = 1;
		while (r_cur != 0) begin
			q = r_prev / r_cur;
			tmp = r_prev - q * r_cur;
			r_prev = r_cur;
			r_cur = tmp;
			tmp = t_prev - q * t_cur;
			t_prev = t_cur;
			t_cur = tmp;
		end
		// gcd of one means an inverse exists; modulus one lands here with t 0
		if (r_prev == 1) begin
			t_prev = t_prev % longint'(m);
			if (t_prev < 0)
				t_prev = t_prev + longint'(m);
			res.inverse = word_t'(t_prev);
			res.invertible = 1'b1;
		end
		return res;
	endfunction

	// random beat: mostly full-range operands, with shares of small moduli,
	// the degenerate moduli and operands that share a factor
	function automatic inv_req_t random_req();
		inv_req_t r;
		int pick;
		int g;
		pick = $urandom_range(99);
		if (pick < 60) begin
			r.value = word_t'($urandom);
			r.modulus = word_t'($urandom);
		end else if (pick < 75) begin
			r.value = word_t'($urandom);
			r.modulus = word_t'($urandom_range(64, 1));
		end else if (pick < 85) begin
			r.value = word_t'($urandom);
			r.modulus = word_t'($urandom_range(1, 0));
		end else begin
			g = $urandom_range(255, 2);
			r.value = word_t'(g * $urandom_range(255, 0));
			r.modulus = word_t'(g * $urandom_range(255, 1));
		end
		return r;
	endfunction

	function automatic inv_req_t mk_req(int v, int m);
		inv_req_t r;
		r.value = word_t'(v);
		r.modulus = word_t'(m);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// request driver: one nonblocking update of valid per edge; the beat in
	// flight is predicted at the edge where the core takes it
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (req_if.valid)
				expected_inverses.push_back(predict_inverse(req_if.value, req_if.modulus));
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt_req = pending_reqs.pop_front();
				req_if.valid <= 1'b1;
				req_if.value <= nxt_req.value;
				req_if.modulus <= nxt_req.modulus;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// response monitor: checks each beat against the oldest prediction, then
	// decides ready for the next edge (random stall or a long counted hold)
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.inverse = rsp_if.inverse;
				got.invertible = rsp_if.invertible;
				if (expected_inverses.size() == 0) begin
					errors++;
					$display("%0t: response beat with nothing expected: inverse %h invertible %b",
						$time, got.inverse, got.invertible);
				end else begin
					want = expected_inverses.pop_front();
					if (got.inverse !== want.inverse) begin
						errors++;
						$display("%0t: inverse mismatch: expected %h, actual %h",
							$time, want.inverse, got.inverse);
					end
					if (got.invertible !== want.invertible) begin
						errors++;
						$display("%0t: invertible mismatch: expected %b, actual %b",
							$time, want.invertible, got.invertible);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_requests != holds_started) begin
				// long hold asked for by the sequencer, counted here
				holds_started++;
				hold_left = HOLD_CYCLES - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: gives up when neither channel moves a beat for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequencer: fills the request queue phase by phase; control variables
	// change on the falling edge so the clocked blocks never race them
	// ------------------------------------------------------------------------
	initial begin
		req_if.valid = 1'b0;
		req_if.value = '0;
		req_if.modulus = '0;
		rsp_if.ready = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 20;
		recv_idle_pct = 64;
		hold_requests = 0;
		holds_started = 0;
		hold_left = 0;
		quiet_cycles = 0;
		errors = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed beats: field extremes and the special cases
		pending_reqs.push_back(mk_req(0, 0));           // zero modulus
		pending_reqs.push_back(mk_req(65535, 0));       // zero modulus, full value
		pending_reqs.push_back(mk_req(0, 1));           // modulus one
		pending_reqs.push_back(mk_req(65535, 1));       // modulus one, full value
		pending_reqs.push_back(mk_req(0, 7));           // value zero, not invertible
		pending_reqs.push_back(mk_req(0, 65535));
		pending_reqs.push_back(mk_req(1, 65535));
		pending_reqs.push_back(mk_req(65535, 65535));   // value equal to modulus
		pending_reqs.push_back(mk_req(65534, 65535));
		pending_reqs.push_back(mk_req(2, 65535));
		pending_reqs.push_back(mk_req(3, 65535));       // shares a factor
		pending_reqs.push_back(mk_req(65535, 65534));   // value above modulus
		pending_reqs.push_back(mk_req(46368, 28657));   // consecutive fibonacci
		pending_reqs.push_back(mk_req(28657, 46368));
		pending_reqs.push_back(mk_req(12345, 32768));   // power-of-two modulus
		pending_reqs.push_back(mk_req(32768, 65535));
		pending_reqs.push_back(mk_req(6, 9));
		pending_reqs.push_back(mk_req(40000, 7));
		pending_reqs.push_back(mk_req(1, 2));
		pending_reqs.push_back(mk_req(2, 3));
		pending_reqs.push_back(mk_req(65520, 65521));   // largest 16-bit prime
		pending_reqs.push_back(mk_req(43690, 21845));   // value a multiple of modulus
		pending_reqs.push_back(mk_req(21845, 43690));

		// phase one: sender idles lightly, receiver heavily
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			pending_reqs.push_back(random_req());
		while (pending_reqs.size() != 0 || req_if.valid || expected_inverses.size() != 0)
			@(negedge clk);

		// phase two: roles swapped; sender paused above until all results came
		send_idle_pct = 64;
		recv_idle_pct = 20;
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			pending_reqs.push_back(random_req());
		while (pending_reqs.size() != 0 || req_if.valid || expected_inverses.size() != 0)
			@(negedge clk);

		// phase three: no idling, with one long response hold up front so the
		// core fills and backs up its request side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests = 1;
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			pending_reqs.push_back(random_req());
		while (pending_reqs.size() != 0 || req_if.valid || expected_inverses.size() != 0)
			@(negedge clk);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
